// ===== rtl/tile_param_stream_parser_macros.svh =====
// assertion macros for the tile parameter stream parser
// each macro takes a label, a clock, a reset, an enabling condition, a consequence and a message
`ifndef TILE_PARAM_STREAM_PARSER_MACROS_SVH
`define TILE_PARAM_STREAM_PARSER_MACROS_SVH

// consequence must hold in the same cycle
`define TPSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the next cycle
`define TPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsp_pkg
// types, codes and decode functions of the tile parameter stream parser
// ----------------------------------------------------------------------------
`default_nettype none

package tpsp_pkg;

    // operation codes of an input item
    localparam logic OP_LIST_INIT = 1'b0;
    localparam logic OP_CHUNK     = 1'b1;

    // parameter kinds
    localparam logic [2:0] PARA_END_LIST  = 3'd0;
    localparam logic [2:0] PARA_TILE_CLIP = 3'd1;
    localparam logic [2:0] PARA_LIST_SET  = 3'd2;
    localparam logic [2:0] PARA_POLYGON   = 3'd4;
    localparam logic [2:0] PARA_SPRITE    = 3'd5;
    localparam logic [2:0] PARA_VERTEX    = 3'd7;

    // list kinds
    localparam logic [2:0] LIST_OPAQUE_MODVOL = 3'd1;
    localparam logic [2:0] LIST_TRANS_MODVOL  = 3'd3;
    localparam logic [2:0] LIST_NONE          = 3'd5;

    // vertex and polygon codes with a special meaning
    localparam logic [4:0] VERT_NONE   = 5'd18;
    localparam logic [4:0] MODVOL_VERT = 5'd17;
    localparam logic [2:0] MODVOL_POLY = 3'd6;

    // decoded control word of a command header
    typedef struct packed {
        logic       short_uv;
        logic       offset_colour;
        logic       textured;
        logic [1:0] colour_kind;
        logic       volume_bit;
        logic [2:0] list_kind;
        logic [2:0] para_kind;
    } hdr_t;

    // one result item
    typedef struct packed {
        logic       command_done;
        logic       command_long;
        logic [2:0] poly_kind;
        logic [4:0] vertex_kind;
        logic [2:0] open_list;
        logic       list_end_irq;
        logic [2:0] ended_list;
        logic       unsupported_cmd;
    } res_t;

    function automatic logic is_modvol(input logic [2:0] list);
        return (list == LIST_OPAQUE_MODVOL) || (list == LIST_TRANS_MODVOL);
    endfunction

    // polygon type from a header
    function automatic logic [2:0] poly_of(input hdr_t h);
        logic [2:0] p;
        p = 3'd0;
        if (is_modvol(h.list_kind))
            p = MODVOL_POLY;
        else if (h.para_kind == PARA_SPRITE)
            p = 3'd5;
        else if (h.volume_bit && (h.colour_kind == 2'd0 || h.colour_kind == 2'd3))
            p = 3'd3;
        else if (h.volume_bit && h.colour_kind == 2'd2)
            p = 3'd4;
        else if (h.colour_kind == 2'd2)
            p = (h.textured && h.offset_colour) ? 3'd2 : 3'd1;
        return p;
    endfunction

    // vertex type from a header
    function automatic logic [4:0] vert_of(input hdr_t h);
        logic [4:0] v;
        logic       col_hi;
        col_hi = h.colour_kind[1];
        if (is_modvol(h.list_kind))
            v = MODVOL_VERT;
        else if (h.para_kind == PARA_SPRITE)
            v = h.textured ? 5'd16 : 5'd15;
        else if (h.volume_bit && h.textured && h.colour_kind == 2'd0)
            v = h.short_uv ? 5'd12 : 5'd11;
        else if (h.volume_bit && h.textured && col_hi)
            v = h.short_uv ? 5'd14 : 5'd13;
        else if (h.volume_bit && h.colour_kind == 2'd0)
            v = 5'd9;
        else if (h.volume_bit && col_hi)
            v = 5'd10;
        else if (h.textured && h.colour_kind == 2'd0)
            v = h.short_uv ? 5'd4 : 5'd3;
        else if (h.textured && h.colour_kind == 2'd1)
            v = h.short_uv ? 5'd6 : 5'd5;
        else if (h.textured)
            v = h.short_uv ? 5'd8 : 5'd7;
        else
            v = col_hi ? 5'd2 : {3'd0, h.colour_kind};
        return v;
    endfunction

    // command takes 64 bytes
    function automatic logic is_long(input logic [2:0] para, input logic [2:0] poly,
                                     input logic [4:0] vtx);
        logic l;
        l = 1'b0;
        if (para == PARA_POLYGON)
            l = !(poly == 3'd0 || poly == 3'd1 || poly == 3'd3);
        else if (para == PARA_VERTEX)
            l = !(vtx <= 5'd4 || (vtx >= 5'd7 && vtx <= 5'd10));
        return l;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tile_param_stream_parser.sv =====
// an accepted item waits in the input register and is decoded into the result register once
// that register is free, that is empty or being read
// throughput: one item per cycle unless out_stall holds a result, set by the single decode pass
// an item is still taken into the input register while a result waits, if that register is empty
// reset: asynchronous, active low; clears the valid flags of both stages, the held header and
// pending flag, and sets the open list and vertex type to none
// ----------------------------------------------------------------------------
// tile_param_stream_parser
// parses 32-byte parameter chunks into commands, tracks open list and vertex type
// ----------------------------------------------------------------------------
`default_nettype none

`include "tile_param_stream_parser_macros.svh"

module tile_param_stream_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       operation,
    input  wire logic [2:0] para_kind,
    input  wire logic [2:0] list_kind,
    input  wire logic       volume_bit,
    input  wire logic [1:0] colour_kind,
    input  wire logic       textured,
    input  wire logic       offset_colour,
    input  wire logic       short_uv,
    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            command_done,
    output logic            command_long,
    output logic [2:0]      poly_kind,
    output logic [4:0]      vertex_kind,
    output logic [2:0]      open_list,
    output logic            list_end_irq,
    output logic [2:0]      ended_list,
    output logic            unsupported_cmd
);

    import tpsp_pkg::*;

    // input stage
    logic s1_valid_reg;
    logic s1_op_reg;
    hdr_t s1_hdr_reg;

    // result stage
    logic out_valid_reg;
    res_t res_reg;

    // parse state
    logic       half_pending_reg, half_pending_next;
    hdr_t       held_header_reg, held_header_next;
    logic [2:0] current_list_reg, current_list_next;
    logic [4:0] current_vertex_reg, current_vertex_next;

    res_t       res_next;
    logic       s2_free;
    logic       s1_fire;
    logic       in_fire;
    hdr_t       hdr;
    logic [2:0] poly;
    logic [4:0] vtx;
    logic       cmd_long;

    // stage handshakes
    assign s2_free  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign in_fire  = in_valid && !in_stall;

    // decode of the active header
    assign hdr      = half_pending_reg ? held_header_reg : s1_hdr_reg;
    assign poly     = poly_of(hdr);
    assign vtx      = vert_of(hdr);
    assign cmd_long = is_long(hdr.para_kind, poly, current_vertex_reg);

    // next parse state and result
    always_comb
    begin
        half_pending_next   = half_pending_reg;
        held_header_next    = held_header_reg;
        current_list_next   = current_list_reg;
        current_vertex_next = current_vertex_reg;
        res_next            = '0;

        if (s1_op_reg == OP_LIST_INIT)
        begin
            half_pending_next   = 1'b0;
            held_header_next    = '0;
            current_list_next   = LIST_NONE;
            current_vertex_next = VERT_NONE;
        end
        else if (!half_pending_reg && cmd_long)
        begin
            half_pending_next = 1'b1;
            held_header_next  = hdr;
        end
        else
        begin
            half_pending_next     = 1'b0;
            held_header_next      = '0;
            res_next.command_done = 1'b1;
            res_next.command_long = half_pending_reg;
            case (hdr.para_kind)
                PARA_END_LIST:
                begin
                    if (current_list_reg < LIST_NONE)
                    begin
                        res_next.list_end_irq = 1'b1;
                        res_next.ended_list   = current_list_reg;
                    end
                    current_list_next   = LIST_NONE;
                    current_vertex_next = VERT_NONE;
                end
                PARA_LIST_SET:
                begin
                    res_next.unsupported_cmd = 1'b1;
                end
                PARA_POLYGON, PARA_SPRITE:
                begin
                    current_vertex_next = vtx;
                    res_next.poly_kind  = poly;
                end
                default:
                begin
                end
            endcase
            // list-opening commands take the list only when none is open
            if ((hdr.para_kind == PARA_LIST_SET || hdr.para_kind == PARA_POLYGON ||
                 hdr.para_kind == PARA_SPRITE) && current_list_reg == LIST_NONE)
                current_list_next = hdr.list_kind;
        end
        res_next.vertex_kind = current_vertex_next;
        res_next.open_list   = current_list_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            half_pending_reg   <= 1'b0;
            held_header_reg    <= '0;
            current_list_reg   <= LIST_NONE;
            current_vertex_reg <= VERT_NONE;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                half_pending_reg   <= half_pending_next;
                held_header_reg    <= held_header_next;
                current_list_reg   <= current_list_next;
                current_vertex_reg <= current_vertex_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg  <= operation;
            s1_hdr_reg <= '{short_uv:      short_uv,
                            offset_colour: offset_colour,
                            textured:      textured,
                            colour_kind:   colour_kind,
                            volume_bit:    volume_bit,
                            list_kind:     list_kind,
                            para_kind:     para_kind};
        end
        if (s1_fire)
            res_reg <= res_next;
    end

    // result ports
    assign out_valid       = out_valid_reg;
    assign command_done    = res_reg.command_done;
    assign command_long    = res_reg.command_long;
    assign poly_kind       = res_reg.poly_kind;
    assign vertex_kind     = res_reg.vertex_kind;
    assign open_list       = res_reg.open_list;
    assign list_end_irq    = res_reg.list_end_irq;
    assign ended_list      = res_reg.ended_list;
    assign unsupported_cmd = res_reg.unsupported_cmd;

    // checks
    `TPSP_ASSERT_NEXT(a_second_half_completes, clk, rst_n,
        s1_fire && s1_op_reg == OP_CHUNK && half_pending_reg,
        out_valid && command_done && command_long, "second half did not complete command")
    `TPSP_ASSERT_NOW(a_long_implies_done, clk, rst_n,
        out_valid && command_long, command_done, "long flag without completed command")
    `TPSP_ASSERT_NOW(a_irq_clears_state, clk, rst_n,
        out_valid && list_end_irq,
        command_done && open_list == LIST_NONE && vertex_kind == VERT_NONE,
        "end-of-list interrupt without cleared list state")
    `TPSP_ASSERT_NOW(a_unsupported_is_short, clk, rst_n,
        out_valid && unsupported_cmd, command_done && !command_long && poly_kind == 3'd0,
        "list set reported as long or with polygon type")
    `TPSP_ASSERT_NOW(a_held_clear_when_idle, clk, rst_n,
        !half_pending_reg, held_header_reg == '0, "held header not cleared")

endmodule

`default_nettype wire

// ===== sim/tile_param_stream_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_param_stream_parser_test
// self-checking bench: drives list inits and parameter chunks through the
// valid/stall input channel, predicts every result item in a scoreboard and
// compares it field by field, under changing idle mixes and back-pressure
// ----------------------------------------------------------------------------

module tile_param_stream_parser_test;

    import tpsp_pkg::*;

    // parameter kinds with no meaning, and list codes the package leaves unnamed
    localparam logic [2:0] PARA_UNKNOWN_LO  = 3'd3;
    localparam logic [2:0] PARA_UNKNOWN_HI  = 3'd6;
    localparam logic [2:0] LIST_OPAQUE      = 3'd0;
    localparam logic [2:0] LIST_TRANSLUCENT = 3'd2;
    localparam logic [2:0] LIST_PUNCH       = 3'd4;
    localparam logic [2:0] LIST_BEYOND     = 3'd7;

    // scoreboard: follows the parse state and holds the awaited result items
    class parse_scoreboard;
        res_t       awaited[$];
        logic       half_held;
        hdr_t       held_hdr;
        logic [2:0] cur_list;
        logic [4:0] cur_vertex;
        int         mismatches;
        int         results_seen;
        int         long_cmds;
        int         irqs;
        int         unsupported;

        function new();
            clear_parse();
            mismatches   = 0;
            results_seen = 0;
            long_cmds    = 0;
            irqs         = 0;
            unsupported  = 0;
        endfunction

        function void clear_parse();
            half_held  = 1'b0;
            held_hdr   = '0;
            cur_list   = LIST_NONE;
            cur_vertex = VERT_NONE;
        endfunction

        // work out the result of one accepted item and queue it
        function void note_item(logic op, hdr_t chunk);
            res_t       want;
            hdr_t       h;
            logic       modvol;
            logic       col_hi;
            logic       two_chunks;
            logic [2:0] poly;
            logic [4:0] vtx;
            want = '0;
            if (op == OP_LIST_INIT)
                clear_parse();
            else
            begin
                // a held first half decides the whole command
                h = half_held ? held_hdr : chunk;
                modvol = (h.list_kind == LIST_OPAQUE_MODVOL) ||
                         (h.list_kind == LIST_TRANS_MODVOL);
                col_hi = h.colour_kind[1];

                // polygon type of the header
                if (modvol)
                    poly = MODVOL_POLY;
                else if (h.para_kind == PARA_SPRITE)
                    poly = 3'd5;
                else if (h.volume_bit && h.colour_kind != 2'd1)
                    poly = (h.colour_kind == 2'd2) ? 3'd4 : 3'd3;
                else if (h.colour_kind == 2'd2)
                    poly = (h.textured && h.offset_colour) ? 3'd2 : 3'd1;
                else
                    poly = 3'd0;

                // vertex type the header selects
                if (modvol)
                    vtx = MODVOL_VERT;
                else if (h.para_kind == PARA_SPRITE)
                    vtx = h.textured ? 5'd16 : 5'd15;
                else if (h.volume_bit && h.colour_kind != 2'd1 && h.textured)
                    vtx = col_hi ? (h.short_uv ? 5'd14 : 5'd13)
                                 : (h.short_uv ? 5'd12 : 5'd11);
                else if (h.volume_bit && h.colour_kind != 2'd1)
                    vtx = col_hi ? 5'd10 : 5'd9;
                else if (h.textured && h.colour_kind == 2'd0)
                    vtx = h.short_uv ? 5'd4 : 5'd3;
                else if (h.textured && h.colour_kind == 2'd1)
                    vtx = h.short_uv ? 5'd6 : 5'd5;
                else if (h.textured)
                    vtx = h.short_uv ? 5'd8 : 5'd7;
                else
                    vtx = col_hi ? 5'd2 : {3'd0, h.colour_kind};

                // command length: polygons by type, vertices by the current vertex type
                if (h.para_kind == PARA_POLYGON)
                    two_chunks = !(poly == 3'd0 || poly == 3'd1 || poly == 3'd3);
                else if (h.para_kind == PARA_VERTEX)
                    two_chunks = !(cur_vertex <= 5'd4 ||
                                   (cur_vertex >= 5'd7 && cur_vertex <= 5'd10));
                else
                    two_chunks = 1'b0;

                if (!half_held && two_chunks)
                begin
                    half_held = 1'b1;
                    held_hdr  = h;
                end
                else
                begin
                    want.command_done = 1'b1;
                    want.command_long = half_held;
                    half_held = 1'b0;
                    held_hdr  = '0;
                    case (h.para_kind)
                        PARA_END_LIST:
                        begin
                            // only a defined open list raises its interrupt
                            if (cur_list < LIST_NONE)
                            begin
                                want.list_end_irq = 1'b1;
                                want.ended_list   = cur_list;
                            end
                            cur_list   = LIST_NONE;
                            cur_vertex = VERT_NONE;
                        end
                        PARA_LIST_SET:
                            want.unsupported_cmd = 1'b1;
                        PARA_POLYGON, PARA_SPRITE:
                        begin
                            cur_vertex     = vtx;
                            want.poly_kind = poly;
                        end
                        default: ;
                    endcase
                    // headers open their list when none is open
                    if ((h.para_kind == PARA_LIST_SET || h.para_kind == PARA_POLYGON ||
                         h.para_kind == PARA_SPRITE) && cur_list == LIST_NONE)
                        cur_list = h.list_kind;
                end
            end
            want.vertex_kind = cur_vertex;
            want.open_list   = cur_list;
            long_cmds   += want.command_long;
            irqs        += want.list_end_irq;
            unsupported += want.unsupported_cmd;
            awaited.push_back(want);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        // compare one accepted result item with the oldest awaited one
        function void check_result(res_t got);
            res_t want;
            if (awaited.size() == 0)
            begin
                $error("result item arrived with none outstanding");
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            results_seen++;
            compare_field("command_done", want.command_done, got.command_done);
            compare_field("command_long", want.command_long, got.command_long);
            compare_field("poly_kind", want.poly_kind, got.poly_kind);
            compare_field("vertex_kind", want.vertex_kind, got.vertex_kind);
            compare_field("open_list", want.open_list, got.open_list);
            compare_field("list_end_irq", want.list_end_irq, got.list_end_irq);
            compare_field("ended_list", want.ended_list, got.ended_list);
            compare_field("unsupported_cmd", want.unsupported_cmd, got.unsupported_cmd);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic drive_op;
    hdr_t drive_hdr;
    logic out_valid;
    logic out_stall;
    logic command_done;
    logic command_long;
    logic [2:0] poly_kind;
    logic [4:0] vertex_kind;
    logic [2:0] open_list;
    logic list_end_irq;
    logic [2:0] ended_list;
    logic unsupported_cmd;
    res_t seen_result;

    parse_scoreboard sb;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;

    tile_param_stream_parser DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (drive_op),
        .para_kind       (drive_hdr.para_kind),
        .list_kind       (drive_hdr.list_kind),
        .volume_bit      (drive_hdr.volume_bit),
        .colour_kind     (drive_hdr.colour_kind),
        .textured        (drive_hdr.textured),
        .offset_colour   (drive_hdr.offset_colour),
        .short_uv        (drive_hdr.short_uv),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .command_done    (command_done),
        .command_long    (command_long),
        .poly_kind       (poly_kind),
        .vertex_kind     (vertex_kind),
        .open_list       (open_list),
        .list_end_irq    (list_end_irq),
        .ended_list      (ended_list),
        .unsupported_cmd (unsupported_cmd)
    );

    always #10 clk = ~clk;

    assign seen_result = {command_done, command_long, poly_kind, vertex_kind, open_list,
                          list_end_irq, ended_list, unsupported_cmd};

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid && !out_stall)
            sb.check_result(seen_result);
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // flag and colour arguments are small integers, cut down to their field widths
    function automatic hdr_t make_hdr(logic [2:0] para, logic [2:0] lst, int vol,
                                      int col, int tex, int off, int uv);
        hdr_t h;
        h.para_kind     = para;
        h.list_kind     = lst;
        h.volume_bit    = vol[0];
        h.colour_kind   = col[1:0];
        h.textured      = tex[0];
        h.offset_colour = off[0];
        h.short_uv      = uv[0];
        return h;
    endfunction

    function automatic hdr_t random_fields();
        hdr_t h;
        h = 12'($urandom);
        return h;
    endfunction

    // offer one item from a falling edge, hold it until accepted
    task automatic send_item(input logic op, input hdr_t fields);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        drive_op  = op;
        drive_hdr = fields;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(op, fields);
        items_sent++;
        @(negedge clk);
    endtask

    // sender pauses until every awaited result item is in
    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.awaited.size() > 0)
            @(negedge clk);
    endtask

    // one well-formed list: headers, vertices, second halves, end of list
    task automatic send_list();
        hdr_t       h;
        logic [2:0] lst;
        int         pick;
        lst = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
        repeat ($urandom_range(3, 1))
        begin
            h = random_fields();
            h.list_kind = lst;
            pick = $urandom_range(99);
            h.para_kind = (pick < 10) ? PARA_LIST_SET :
                          (pick < 35) ? PARA_SPRITE : PARA_POLYGON;
            send_item(OP_CHUNK, h);
            if (sb.half_held)
                send_item(OP_CHUNK, random_fields());
            repeat ($urandom_range(6, 1))
            begin
                h = random_fields();
                h.para_kind = ($urandom_range(99) < 8) ? PARA_TILE_CLIP : PARA_VERTEX;
                send_item(OP_CHUNK, h);
                if (sb.half_held)
                    send_item(OP_CHUNK, random_fields());
            end
        end
        h = random_fields();
        h.para_kind = PARA_END_LIST;
        send_item(OP_CHUNK, h);
    endtask

    // mostly well-formed lists, the rest list inits and noise
    task automatic random_phase(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_item(($urandom_range(9) == 0) ? OP_LIST_INIT : OP_CHUNK,
                          random_fields());
            else if (pick < 18)
                send_item(OP_LIST_INIT, random_fields());
            else
                send_list();
        end
    endtask

    // main sequence
    initial
    begin
        sb = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        drive_op      = OP_LIST_INIT;
        drive_hdr     = '0;
        items_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: list init, end of list with nothing open, minor kinds
        send_item(OP_LIST_INIT, '1);
        send_item(OP_CHUNK, '0);
        send_item(OP_CHUNK, make_hdr(PARA_TILE_CLIP, LIST_OPAQUE, 0, 0, 0, 0, 0));
        send_item(OP_CHUNK, make_hdr(PARA_UNKNOWN_LO, LIST_TRANSLUCENT, 1, 3, 1, 1, 1));
        send_item(OP_CHUNK, make_hdr(PARA_UNKNOWN_HI, LIST_OPAQUE, 0, 1, 0, 0, 0));
        // vertex with no vertex type takes two chunks; second half fields ignored
        send_item(OP_CHUNK, make_hdr(PARA_VERTEX, LIST_OPAQUE, 0, 0, 0, 0, 0));
        send_item(OP_CHUNK, make_hdr(PARA_END_LIST, LIST_PUNCH, 1, 1, 1, 1, 1));
        // object list set opens the opaque list
        send_item(OP_CHUNK, make_hdr(PARA_LIST_SET, LIST_OPAQUE, 0, 0, 0, 0, 0));
        // long polygon header, two short vertices, end of list with interrupt
        send_item(OP_CHUNK, make_hdr(PARA_POLYGON, LIST_OPAQUE, 0, 2, 1, 1, 1));
        send_item(OP_CHUNK, make_hdr(PARA_SPRITE, LIST_TRANS_MODVOL, 0, 0, 0, 0, 0));
        repeat (2) send_item(OP_CHUNK, make_hdr(PARA_VERTEX, LIST_OPAQUE, 0, 0, 0, 0, 0));
        send_item(OP_CHUNK, make_hdr(PARA_END_LIST, LIST_OPAQUE, 0, 0, 0, 0, 0));
        // textured sprite in the translucent list
        send_item(OP_CHUNK, make_hdr(PARA_SPRITE, LIST_TRANSLUCENT, 0, 0, 1, 0, 0));
        repeat (2) send_item(OP_CHUNK, make_hdr(PARA_VERTEX, LIST_OPAQUE, 0, 0, 0, 0, 0));
        // modifier volume header while a list is already open
        repeat (2)
            send_item(OP_CHUNK, make_hdr(PARA_POLYGON, LIST_TRANS_MODVOL, 0, 0, 0, 0, 0));
        repeat (2) send_item(OP_CHUNK, make_hdr(PARA_VERTEX, LIST_OPAQUE, 0, 0, 0, 0, 0));
        send_item(OP_CHUNK, make_hdr(PARA_END_LIST, LIST_OPAQUE, 0, 0, 0, 0, 0));
        // list code beyond the defined lists: kept open, no interrupt at its end
        send_item(OP_CHUNK, make_hdr(PARA_POLYGON, LIST_BEYOND, 1, 3, 1, 1, 1));
        send_item(OP_CHUNK, make_hdr(PARA_END_LIST, LIST_OPAQUE, 0, 0, 0, 0, 0));
        // two-volume header in punch-through, then a list init mid-list
        repeat (2) send_item(OP_CHUNK, make_hdr(PARA_POLYGON, LIST_PUNCH, 1, 2, 0, 0, 0));
        send_item(OP_LIST_INIT, '0);
        wait_drained();

        // sender idles lightly, receiver heavily, with one long hold-off
        send_idle_pct = 29;
        recv_idle_pct = 75;
        hold_request  = 80;
        random_phase(400);
        wait_drained();

        send_idle_pct = 75;
        recv_idle_pct = 29;
        random_phase(400);
        wait_drained();

        // no idling; a second hold-off fills the block at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 60;
        random_phase(400);
        wait_drained();
        repeat (8) @(negedge clk);

        $display("covered %0d items: directed kinds, well-formed lists, noise, three idle mixes",
                 items_sent);
        $display("checked %0d results: %0d 64-byte commands, %0d list-end irqs, %0d unsupported",
                 sb.results_seen, sb.long_cmds, sb.irqs, sb.unsupported);
        if (sb.mismatches == 0)
            $display("tile_param_stream_parser_test OK");
        else
            $display("tile_param_stream_parser_test NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("tile_param_stream_parser_test NOT OK");
        $finish;
    end

endmodule
